// ===== rtl/arcpg_pkg.sv =====
package arcpg_pkg;

    localparam int MIN_SEGMENTS_DEF = 1;
    localparam int MAX_SEGMENTS_DEF = 63;
    localparam int CORDIC_STEPS     = 28;

    localparam logic [31:0]        SEED_LIMIT  = 32'd966367642;
    localparam logic signed [39:0] TWO_PI      = 40'sd1686629713;
    localparam logic signed [39:0] PI          = 40'sd843314857;
    localparam logic signed [39:0] HALF_PI     = 40'sd421657428;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_RADIUS  = 3'd1;
    localparam logic [2:0] ERR_SWEEP   = 3'd2;
    localparam logic [2:0] ERR_SEGS    = 3'd3;
    localparam logic [2:0] ERR_NORMAL  = 3'd4;

    localparam logic DS_DIV  = 1'b0;
    localparam logic DS_SQRT = 1'b1;

    typedef struct packed {
        logic signed [31:0] centre_x;
        logic signed [31:0] centre_y;
        logic signed [31:0] centre_z;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic signed [31:0] radius_value;
        logic signed [31:0] start_angle;
        logic signed [31:0] sweep_angle;
        logic [7:0]         segment_count;
    } arcpg_in_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [2:0]         error_code;
        logic               last_point;
    } arcpg_out_t;

    typedef struct packed {
        logic start;
        logic mode;
    } arcpg_ds_ctl_t;

    function automatic logic [27:0] atan_q28(input logic [4:0] k);
        logic [27:0] v;
        case (k)
            5'd0:    v = 28'd210828714;
            5'd1:    v = 28'd124459457;
            5'd2:    v = 28'd65760959;
            5'd3:    v = 28'd33381290;
            5'd4:    v = 28'd16755422;
            5'd5:    v = 28'd8385879;
            5'd6:    v = 28'd4193963;
            5'd7:    v = 28'd2097109;
            5'd8:    v = 28'd1048571;
            5'd9:    v = 28'd524287;
            default: v = 28'd1 << (5'd28 - k);
        endcase
        return v;
    endfunction

    // round half away from zero, divide by 2^30
    function automatic logic signed [35:0] round_q30(input logic signed [65:0] v);
        logic [65:0] mag;
        logic [65:0] m;
        mag = v[65] ? 66'(-v) : 66'(v);
        m   = (mag + (66'd1 << 29)) >> 30;
        return v[65] ? -$signed(m[35:0]) : $signed(m[35:0]);
    endfunction

endpackage

// ===== rtl/arc_point_generator.sv =====
// channel | direction | handshake              | payload
// arc     | in        | arc_valid / arc_ready   | arcpg_in_t, one request per arc
// point   | out       | point_valid / point_ready | arcpg_out_t, segments+1 points or one error
//
// setup: three normalisations, each a scale, sum of squares, root and three divides in
// the shared divide/root unit, a cross product and a sweep divide; each point then takes
// an angle reduction, a cordic rotation, radius and axis multiplies and the output step
// a failed check gives its error in the cycle after acceptance; reset clears the sequencer
// and the output valid; arc_ready is high only when idle; a stalled point holds the sequencer
module arc_point_generator #(
    parameter int MIN_SEGMENTS = arcpg_pkg::MIN_SEGMENTS_DEF,
    parameter int MAX_SEGMENTS = arcpg_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  arc_valid,
    output logic                  arc_ready,
    input  arcpg_pkg::arcpg_in_t  arc,
    output logic                  point_valid,
    input  logic                  point_ready,
    output arcpg_pkg::arcpg_out_t point
);

    // sequencer states
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_NMAG   = 5'd1;
    localparam logic [4:0] S_NSCALE = 5'd2;
    localparam logic [4:0] S_NSQ    = 5'd3;
    localparam logic [4:0] S_NACC   = 5'd4;
    localparam logic [4:0] S_NSQRT  = 5'd5;
    localparam logic [4:0] S_NSQRTW = 5'd6;
    localparam logic [4:0] S_NDIV   = 5'd7;
    localparam logic [4:0] S_NDIVW  = 5'd8;
    localparam logic [4:0] S_NRET   = 5'd9;
    localparam logic [4:0] S_CRA    = 5'd10;
    localparam logic [4:0] S_CRB    = 5'd11;
    localparam logic [4:0] S_CRC    = 5'd12;
    localparam logic [4:0] S_ADIV   = 5'd13;
    localparam logic [4:0] S_ADIVW  = 5'd14;
    localparam logic [4:0] S_ANG    = 5'd15;
    localparam logic [4:0] S_RED    = 5'd16;
    localparam logic [4:0] S_FOLD   = 5'd17;
    localparam logic [4:0] S_CORW   = 5'd18;
    localparam logic [4:0] S_RCA    = 5'd19;
    localparam logic [4:0] S_RCB    = 5'd20;
    localparam logic [4:0] S_RSC    = 5'd21;
    localparam logic [4:0] S_PA     = 5'd22;
    localparam logic [4:0] S_PB     = 5'd23;
    localparam logic [4:0] S_PC     = 5'd24;
    localparam logic [4:0] S_OUT    = 5'd25;

    // which vector the normaliser is working on
    localparam logic [1:0] NV_NORMAL = 2'd0;
    localparam logic [1:0] NV_XAXIS  = 2'd1;
    localparam logic [1:0] NV_YAXIS  = 2'd2;

    logic [4:0]            state_reg, state_next;
    logic                  out_valid_reg, out_valid_next;
    arcpg_pkg::arcpg_out_t out_reg, out_next;
    arcpg_pkg::arcpg_in_t  req_reg, req_next;

    logic signed [32:0] vin_reg [3];
    logic signed [32:0] vin_next [3];
    logic [31:0]        m_reg [3];
    logic [31:0]        m_next [3];
    logic signed [31:0] u_reg [3];
    logic signed [31:0] u_next [3];
    logic signed [31:0] un_reg [3];
    logic signed [31:0] un_next [3];
    logic signed [31:0] ax_reg [3];
    logic signed [31:0] ax_next [3];
    logic signed [31:0] ay_reg [3];
    logic signed [31:0] ay_next [3];
    logic signed [31:0] pt_reg [3];
    logic signed [31:0] pt_next [3];

    logic [1:0]         nsel_reg, nsel_next;
    logic [1:0]         j_reg, j_next;
    logic [63:0]        sum_reg, sum_next;
    logic [31:0]        len_reg, len_next;
    logic signed [65:0] prod_reg, prod_next;
    logic signed [65:0] acc_reg, acc_next;
    logic [31:0]        qa_reg, qa_next;
    logic [5:0]         qb_reg, qb_next;
    logic [37:0]        qq_reg, qq_next;
    logic [6:0]         qr_reg, qr_next;
    logic [5:0]         i_reg, i_next;
    logic [39:0]        ang_reg, ang_next;
    logic               angneg_reg, angneg_next;
    logic [2:0]         k_reg, k_next;
    logic               fneg_reg, fneg_next;
    logic signed [33:0] cs_reg, cs_next;
    logic signed [33:0] sn_reg, sn_next;
    logic signed [33:0] rc_reg, rc_next;
    logic signed [33:0] rs_reg, rs_next;

    // shared multiplier
    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [67:0] mul_p;

    // shared divide / root unit
    arcpg_pkg::arcpg_ds_ctl_t ds_ctl;
    logic [63:0]        ds_a;
    logic [31:0]        ds_b;
    logic               ds_done;
    logic [63:0]        ds_q;
    logic [31:0]        ds_r;

    logic               cor_start;
    logic signed [31:0] cor_angle;
    logic               cor_done;
    logic signed [33:0] cor_cos;
    logic signed [33:0] cor_sin;

    logic [1:0]         ia;
    logic [1:0]         ib;
    logic [2:0]         err;
    logic [7:0]         segs;
    logic signed [39:0] a_full;
    logic signed [39:0] qsig;
    logic signed [39:0] zf;
    logic [39:0]        twopi_k;
    logic [7:0]         rnext;
    logic signed [35:0] rq;
    logic signed [36:0] psum;
    logic signed [31:0] ctr;
    logic [31:0]        sweep_mag;
    logic [63:0]        dvd;

    assign mul_p = mul_a * mul_b;

    arcpg_divsqrt u_divsqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ds_ctl),
        .opa       (ds_a),
        .opb       (ds_b),
        .done      (ds_done),
        .result    (ds_q),
        .remainder (ds_r)
    );

    arcpg_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cor_start),
        .angle   (cor_angle),
        .done    (cor_done),
        .cos_out (cor_cos),
        .sin_out (cor_sin)
    );

    // cross product operand indices: t[j] = un[ia]*ax[ib] - un[ib]*ax[ia]
    always_comb
    begin
        case (j_reg)
            2'd0:    begin ia = 2'd1; ib = 2'd2; end
            2'd1:    begin ia = 2'd2; ib = 2'd0; end
            default: begin ia = 2'd0; ib = 2'd1; end
        endcase
    end

    // argument checks in priority order
    always_comb
    begin
        if (arc.radius_value <= 32'sd0)
            err = arcpg_pkg::ERR_RADIUS;
        else if (arc.sweep_angle == 32'sd0)
            err = arcpg_pkg::ERR_SWEEP;
        else if (int'(arc.segment_count) < MIN_SEGMENTS ||
                 int'(arc.segment_count) > MAX_SEGMENTS ||
                 arc.segment_count == 8'd0)
            err = arcpg_pkg::ERR_SEGS;
        else if (arc.normal_x == 32'sd0 && arc.normal_y == 32'sd0 && arc.normal_z == 32'sd0)
            err = arcpg_pkg::ERR_NORMAL;
        else
            err = arcpg_pkg::ERR_NONE;
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        req_next       = req_reg;
        vin_next       = vin_reg;
        m_next         = m_reg;
        u_next         = u_reg;
        un_next        = un_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        pt_next        = pt_reg;
        nsel_next      = nsel_reg;
        j_next         = j_reg;
        sum_next       = sum_reg;
        len_next       = len_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        qa_next        = qa_reg;
        qb_next        = qb_reg;
        qq_next        = qq_reg;
        qr_next        = qr_reg;
        i_next         = i_reg;
        ang_next       = ang_reg;
        angneg_next    = angneg_reg;
        k_next         = k_reg;
        fneg_next      = fneg_reg;
        cs_next        = cs_reg;
        sn_next        = sn_reg;
        rc_next        = rc_reg;
        rs_next        = rs_reg;

        mul_a      = '0;
        mul_b      = '0;
        ds_ctl     = '{start: 1'b0, mode: arcpg_pkg::DS_DIV};
        ds_a       = '0;
        ds_b       = '0;
        cor_start  = 1'b0;
        cor_angle  = '0;

        segs       = req_reg.segment_count;
        sweep_mag  = req_reg.sweep_angle[31] ? 32'(-$signed({1'b1, req_reg.sweep_angle}))
                                             : 32'(req_reg.sweep_angle);
        dvd        = ({32'd0, m_reg[j_reg]} << 30) + 64'(len_reg >> 1);
        qsig       = req_reg.sweep_angle[31] ? -$signed({2'b00, qq_reg})
                                             : $signed({2'b00, qq_reg});
        a_full     = 40'(req_reg.start_angle) + qsig;
        twopi_k    = 40'(arcpg_pkg::TWO_PI) << k_reg;
        rnext      = {1'b0, qr_reg} + {2'b00, qb_reg};
        zf         = (angneg_reg && ang_reg != 40'd0) ? arcpg_pkg::TWO_PI - $signed(ang_reg)
                                                      : $signed(ang_reg);
        rq         = arcpg_pkg::round_q30(acc_reg + prod_reg);
        case (j_reg)
            2'd0:    ctr = req_reg.centre_x;
            2'd1:    ctr = req_reg.centre_y;
            default: ctr = req_reg.centre_z;
        endcase
        psum       = 37'(ctr) + 37'(rq);

        // multiplier operand select
        case (state_reg)
            S_NSQ:
            begin
                mul_a = $signed({2'b00, m_reg[j_reg]});
                mul_b = $signed({2'b00, m_reg[j_reg]});
            end
            S_CRA:
            begin
                mul_a = 34'(un_reg[ia]);
                mul_b = 34'(ax_reg[ib]);
            end
            S_CRB:
            begin
                mul_a = 34'(un_reg[ib]);
                mul_b = 34'(ax_reg[ia]);
            end
            S_RCA:
            begin
                mul_a = 34'(req_reg.radius_value);
                mul_b = cs_reg;
            end
            S_RCB:
            begin
                mul_a = 34'(req_reg.radius_value);
                mul_b = sn_reg;
            end
            S_PA:
            begin
                mul_a = 34'(ax_reg[j_reg]);
                mul_b = rc_reg;
            end
            S_PB:
            begin
                mul_a = 34'(ay_reg[j_reg]);
                mul_b = rs_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase

        case (state_reg)
            S_IDLE:
            begin
                if (arc_valid)
                begin
                    req_next = arc;
                    if (err != arcpg_pkg::ERR_NONE)
                    begin
                        out_next       = '{point_x: '0, point_y: '0, point_z: '0,
                                           error_code: err, last_point: 1'b1};
                        out_valid_next = 1'b1;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        vin_next[0] = 33'(arc.normal_x);
                        vin_next[1] = 33'(arc.normal_y);
                        vin_next[2] = 33'(arc.normal_z);
                        nsel_next   = NV_NORMAL;
                        state_next  = S_NMAG;
                    end
                end
            end

            // ---- normaliser: scale, sum of squares, root, three divides
            S_NMAG:
            begin
                for (int n = 0; n < 3; n++)
                    m_next[n] = vin_reg[n][32] ? 32'(-vin_reg[n]) : 32'(vin_reg[n]);
                if (vin_reg[0] == '0 && vin_reg[1] == '0 && vin_reg[2] == '0)
                begin
                    for (int n = 0; n < 3; n++)
                        u_next[n] = '0;
                    state_next = S_NRET;
                end
                else
                begin
                    state_next = S_NSCALE;
                end
            end
            S_NSCALE:
            begin
                if ((m_reg[0][31:30] | m_reg[1][31:30] | m_reg[2][31:30]) == 2'b00)
                begin
                    for (int n = 0; n < 3; n++)
                        m_next[n] = m_reg[n] << 1;
                end
                else
                begin
                    j_next     = 2'd0;
                    sum_next   = '0;
                    state_next = S_NSQ;
                end
            end
            S_NSQ:
            begin
                prod_next  = mul_p[65:0];
                state_next = S_NACC;
            end
            S_NACC:
            begin
                sum_next = sum_reg + prod_reg[63:0];
                if (j_reg == 2'd2)
                begin
                    state_next = S_NSQRT;
                end
                else
                begin
                    j_next     = j_reg + 2'd1;
                    state_next = S_NSQ;
                end
            end
            S_NSQRT:
            begin
                ds_ctl     = '{start: 1'b1, mode: arcpg_pkg::DS_SQRT};
                ds_a       = sum_reg;
                state_next = S_NSQRTW;
            end
            S_NSQRTW:
            begin
                if (ds_done)
                begin
                    len_next   = (ds_q[31:0] == 32'd0) ? 32'd1 : ds_q[31:0];
                    j_next     = 2'd0;
                    state_next = S_NDIV;
                end
            end
            S_NDIV:
            begin
                ds_ctl     = '{start: 1'b1, mode: arcpg_pkg::DS_DIV};
                ds_a       = dvd;
                ds_b       = len_reg;
                state_next = S_NDIVW;
            end
            S_NDIVW:
            begin
                if (ds_done)
                begin
                    u_next[j_reg] = vin_reg[j_reg][32] ? -$signed(ds_q[31:0])
                                                       : $signed(ds_q[31:0]);
                    if (j_reg == 2'd2)
                    begin
                        state_next = S_NRET;
                    end
                    else
                    begin
                        j_next     = j_reg + 2'd1;
                        state_next = S_NDIV;
                    end
                end
            end
            S_NRET:
            begin
                case (nsel_reg)
                    NV_NORMAL:
                    begin
                        un_next = u_reg;
                        // seed z unless the normal points mostly along z
                        if ((u_reg[2][31] ? 32'(-u_reg[2]) : 32'(u_reg[2])) < arcpg_pkg::SEED_LIMIT)
                        begin
                            vin_next[0] = 33'(u_reg[1]);
                            vin_next[1] = -33'(u_reg[0]);
                            vin_next[2] = '0;
                        end
                        else
                        begin
                            vin_next[0] = '0;
                            vin_next[1] = 33'(u_reg[2]);
                            vin_next[2] = -33'(u_reg[1]);
                        end
                        nsel_next  = NV_XAXIS;
                        state_next = S_NMAG;
                    end
                    NV_XAXIS:
                    begin
                        ax_next    = u_reg;
                        j_next     = 2'd0;
                        state_next = S_CRA;
                    end
                    default:
                    begin
                        ay_next    = u_reg;
                        state_next = S_ADIV;
                    end
                endcase
            end

            // ---- y axis direction = n x xaxis
            S_CRA:
            begin
                prod_next  = mul_p[65:0];
                state_next = S_CRB;
            end
            S_CRB:
            begin
                acc_next   = prod_reg;
                prod_next  = mul_p[65:0];
                state_next = S_CRC;
            end
            S_CRC:
            begin
                vin_next[j_reg] = 33'(arcpg_pkg::round_q30(acc_reg - prod_reg));
                if (j_reg == 2'd2)
                begin
                    nsel_next  = NV_YAXIS;
                    state_next = S_NMAG;
                end
                else
                begin
                    j_next     = j_reg + 2'd1;
                    state_next = S_CRA;
                end
            end

            // ---- |sweep| = qa*segs + qb, angle steps then track by add
            S_ADIV:
            begin
                ds_ctl     = '{start: 1'b1, mode: arcpg_pkg::DS_DIV};
                ds_a       = {32'd0, sweep_mag};
                ds_b       = {24'd0, segs};
                state_next = S_ADIVW;
            end
            S_ADIVW:
            begin
                if (ds_done)
                begin
                    qa_next    = ds_q[31:0];
                    qb_next    = ds_r[5:0];
                    qq_next    = '0;
                    qr_next    = 7'(segs >> 1);
                    i_next     = '0;
                    state_next = S_ANG;
                end
            end

            // ---- angle reduction modulo 2 pi, one compare-subtract a cycle
            S_ANG:
            begin
                angneg_next = a_full[39];
                ang_next    = a_full[39] ? 40'(-a_full) : 40'(a_full);
                k_next      = 3'd7;
                state_next  = S_RED;
            end
            S_RED:
            begin
                if (ang_reg >= twopi_k)
                    ang_next = ang_reg - twopi_k;
                k_next = k_reg - 3'd1;
                if (k_reg == 3'd0)
                    state_next = S_FOLD;
            end
            S_FOLD:
            begin
                if (zf > arcpg_pkg::PI)
                    zf = zf - arcpg_pkg::TWO_PI;
                fneg_next = 1'b0;
                if (zf > arcpg_pkg::HALF_PI)
                begin
                    zf        = zf - arcpg_pkg::PI;
                    fneg_next = 1'b1;
                end
                else if (zf < -arcpg_pkg::HALF_PI)
                begin
                    zf        = zf + arcpg_pkg::PI;
                    fneg_next = 1'b1;
                end
                cor_start  = 1'b1;
                cor_angle  = zf[31:0];
                state_next = S_CORW;
            end
            S_CORW:
            begin
                if (cor_done)
                begin
                    cs_next    = fneg_reg ? -cor_cos : cor_cos;
                    sn_next    = fneg_reg ? -cor_sin : cor_sin;
                    state_next = S_RCA;
                end
            end

            // ---- scale by radius, then project onto the axes
            S_RCA:
            begin
                prod_next  = mul_p[65:0];
                state_next = S_RCB;
            end
            S_RCB:
            begin
                rc_next    = 34'(arcpg_pkg::round_q30(prod_reg));
                prod_next  = mul_p[65:0];
                state_next = S_RSC;
            end
            S_RSC:
            begin
                rs_next    = 34'(arcpg_pkg::round_q30(prod_reg));
                j_next     = 2'd0;
                state_next = S_PA;
            end
            S_PA:
            begin
                prod_next  = mul_p[65:0];
                state_next = S_PB;
            end
            S_PB:
            begin
                acc_next   = prod_reg;
                prod_next  = mul_p[65:0];
                state_next = S_PC;
            end
            S_PC:
            begin
                // saturate to the int32 range
                if (psum > 37'sd2147483647)
                    pt_next[j_reg] = 32'sh7fffffff;
                else if (psum < -37'sd2147483648)
                    pt_next[j_reg] = 32'sh80000000;
                else
                    pt_next[j_reg] = psum[31:0];
                if (j_reg == 2'd2)
                begin
                    out_next.point_x    = pt_reg[0];
                    out_next.point_y    = pt_reg[1];
                    out_next.point_z    = pt_next[2];
                    out_next.error_code = arcpg_pkg::ERR_NONE;
                    out_next.last_point = (8'(i_reg) == segs);
                    out_valid_next      = 1'b1;
                    state_next          = S_OUT;
                end
                else
                begin
                    j_next     = j_reg + 2'd1;
                    state_next = S_PA;
                end
            end

            S_OUT:
            begin
                if (point_ready)
                begin
                    out_valid_next = 1'b0;
                    if (out_reg.last_point)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        if (rnext >= {1'b0, segs[6:0]})
                        begin
                            qr_next = 7'(rnext - {1'b0, segs[6:0]});
                            qq_next = qq_reg + 38'(qa_reg) + 38'd1;
                        end
                        else
                        begin
                            qr_next = rnext[6:0];
                            qq_next = qq_reg + 38'(qa_reg);
                        end
                        i_next     = i_reg + 6'd1;
                        state_next = S_ANG;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg    <= out_next;
        req_reg    <= req_next;
        vin_reg    <= vin_next;
        m_reg      <= m_next;
        u_reg      <= u_next;
        un_reg     <= un_next;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        pt_reg     <= pt_next;
        nsel_reg   <= nsel_next;
        j_reg      <= j_next;
        sum_reg    <= sum_next;
        len_reg    <= len_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        qa_reg     <= qa_next;
        qb_reg     <= qb_next;
        qq_reg     <= qq_next;
        qr_reg     <= qr_next;
        i_reg      <= i_next;
        ang_reg    <= ang_next;
        angneg_reg <= angneg_next;
        k_reg      <= k_next;
        fneg_reg   <= fneg_next;
        cs_reg     <= cs_next;
        sn_reg     <= sn_next;
        rc_reg     <= rc_next;
        rs_reg     <= rs_next;
    end

    assign arc_ready   = (state_reg == S_IDLE);
    assign point_valid = out_valid_reg;
    assign point       = out_reg;

endmodule

// ===== rtl/arcpg_divsqrt.sv =====
module arcpg_divsqrt (
    input  logic                    clk,
    input  logic                    rst_n,
    input  arcpg_pkg::arcpg_ds_ctl_t ctl,
    input  logic [63:0]             opa,
    input  logic [31:0]             opb,
    output logic                    done,
    output logic [63:0]             result,
    output logic [31:0]             remainder
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        mode_reg, mode_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] a_reg, a_next;
    logic [63:0] q_reg, q_next;
    logic [31:0] r_reg, r_next;
    logic [31:0] b_reg, b_next;
    logic [63:0] bit_reg, bit_next;
    logic [32:0] r2;
    logic [32:0] rd;
    logic [63:0] t;
    logic        last;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        b_next    = b_reg;
        bit_next  = bit_reg;
        r2        = {r_reg, a_reg[63]};
        rd        = r2 - {1'b0, b_reg};
        t         = q_reg + bit_reg;
        last      = (mode_reg == arcpg_pkg::DS_SQRT) ? (cnt_reg == 7'd31) : (cnt_reg == 7'd63);
        if (ctl.start)
        begin
            busy_next = 1'b1;
            mode_next = ctl.mode;
            cnt_next  = '0;
            a_next    = opa;
            b_next    = opb;
            q_next    = '0;
            r_next    = '0;
            bit_next  = 64'd1 << 62;
        end
        else if (busy_reg)
        begin
            if (mode_reg == arcpg_pkg::DS_SQRT)
            begin
                // one root bit per cycle
                if (a_reg >= t)
                begin
                    a_next = a_reg - t;
                    q_next = (q_reg >> 1) + bit_reg;
                end
                else
                begin
                    q_next = q_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end
            else
            begin
                // restoring divide, one quotient bit per cycle
                a_next = {a_reg[62:0], 1'b0};
                if (!rd[32])
                begin
                    r_next = rd[31:0];
                    q_next = {q_reg[62:0], 1'b1};
                end
                else
                begin
                    r_next = r2[31:0];
                    q_next = {q_reg[62:0], 1'b0};
                end
            end
            cnt_next = cnt_reg + 7'd1;
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        cnt_reg  <= cnt_next;
        a_reg    <= a_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
        b_reg    <= b_next;
        bit_reg  <= bit_next;
    end

    assign done      = done_reg;
    assign result    = q_reg;
    assign remainder = r_reg;

endmodule

// ===== rtl/arcpg_cordic.sv =====
module arcpg_cordic (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] angle,
    output logic               done,
    output logic signed [33:0] cos_out,
    output logic signed [33:0] sin_out
);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [4:0]         k_reg, k_next;
    logic signed [33:0] x_reg, x_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [31:0] z_reg, z_next;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [31:0] at;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        k_next    = k_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        dx        = y_reg >>> k_reg;
        dy        = x_reg >>> k_reg;
        at        = $signed({4'd0, arcpg_pkg::atan_q28(k_reg)});
        if (start)
        begin
            busy_next = 1'b1;
            k_next    = '0;
            x_next    = arcpg_pkg::CORDIC_GAIN;
            y_next    = '0;
            z_next    = angle;
        end
        else if (busy_reg)
        begin
            if (!z_reg[31])
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - at;
            end
            else
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + at;
            end
            k_next = k_reg + 5'd1;
            if (k_reg == 5'(arcpg_pkg::CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done    = done_reg;
    assign cos_out = x_reg;
    assign sin_out = y_reg;

endmodule

// ===== test/tb_arc_point_generator.sv =====
module tb_arc_point_generator;
    timeunit 1ns;
    timeprecision 1ps;

    typedef longint vec3_t [3];

    // one directed row: the arc request and, where it is plain, its error code
    typedef struct {
        arcpg_pkg::arcpg_in_t arc;
        logic [2:0]           err;
    } arc_row_t;

    localparam int     RANDOM_ARCS = 215;
    localparam longint PI_Q28      = 843314857;
    localparam longint TWO_PI_Q28  = 1686629713;
    localparam longint HALF_PI_Q28 = 421657428;
    localparam longint GAIN_Q30    = 652032874;
    localparam longint SEED_Q30    = 966367642;

    logic                  clk;
    logic                  rst_n;
    logic                  arc_valid;
    logic                  arc_ready;
    arcpg_pkg::arcpg_in_t  arc;
    logic                  point_valid;
    logic                  point_ready;
    arcpg_pkg::arcpg_out_t point;

    arcpg_pkg::arcpg_out_t points_due[$];
    arc_row_t              arc_rows[$];
    int                    mismatches = 0;
    logic                  steady;

    arc_point_generator dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .arc_valid   (arc_valid),
        .arc_ready   (arc_ready),
        .arc         (arc),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point       (point)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    task automatic report(input string msg);
        mismatches++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // append one expected point
    task automatic queue_point(input arcpg_pkg::arcpg_out_t p);
        points_due = {points_due, p};
    endtask

    // append one directed row
    task automatic add_row(input arcpg_pkg::arcpg_in_t a, input logic [2:0] code);
        arc_row_t r;
        r.arc    = a;
        r.err    = code;
        arc_rows = {arc_rows, r};
    endtask

    // ---------------------------------------------------------------
    // arithmetic of the block
    // ---------------------------------------------------------------

    // round half away from zero, divide by 2^s
    function automatic longint round_shift(input longint v, input int s);
        longint unsigned m;
        m = ((v < 0) ? longint'(-v) : v);
        m = (m + (64'd1 << (s - 1))) >> s;
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // unit vector in Q1.30, zero stays zero
    function automatic void unit_vec(input vec3_t v, output vec3_t u);
        longint unsigned m [3];
        longint unsigned big;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned q;
        big = 0;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = (v[i] < 0) ? longint'(-v[i]) : v[i];
            if (m[i] > big)
                big = m[i];
        end
        if (big == 0)
        begin
            u = '{0, 0, 0};
            return;
        end
        while (big < (64'd1 << 30))
        begin
            big <<= 1;
            for (int i = 0; i < 3; i++)
                m[i] <<= 1;
        end
        for (int i = 0; i < 3; i++)
            sum += m[i] * m[i];
        len = int_sqrt(sum);
        if (len == 0)
            len = 1;
        for (int i = 0; i < 3; i++)
        begin
            q    = ((m[i] << 30) + (len >> 1)) / len;
            u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
        end
    endfunction

    // cordic rotation in Q1.30 after reduction into [-pi/2, pi/2]
    function automatic void cordic_sin_cos(input longint angle, output longint c,
                                           output longint s);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        logic   flip;
        z    = angle % TWO_PI_Q28;
        x    = GAIN_Q30;
        y    = 0;
        flip = 1'b0;
        if (z < 0)
            z += TWO_PI_Q28;
        if (z > PI_Q28)
            z -= TWO_PI_Q28;
        if (z > HALF_PI_Q28)
        begin
            z -= PI_Q28;
            flip = 1'b1;
        end
        else if (z < -HALF_PI_Q28)
        begin
            z += PI_Q28;
            flip = 1'b1;
        end
        for (int k = 0; k < arcpg_pkg::CORDIC_STEPS; k++)
        begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= longint'(arcpg_pkg::atan_q28(5'(k)));
            end
            else
            begin
                x += dx;
                y -= dy;
                z += longint'(arcpg_pkg::atan_q28(5'(k)));
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic arcpg_pkg::arcpg_out_t error_point(input logic [2:0] code);
        arcpg_pkg::arcpg_out_t p;
        p            = '0;
        p.error_code = code;
        p.last_point = 1'b1;
        return p;
    endfunction

    // expected points of one arc request, appended to the queue
    task automatic predict_arc_points(input arcpg_pkg::arcpg_in_t a);
        vec3_t                 ctr;
        vec3_t                 nrm;
        vec3_t                 un;
        vec3_t                 t;
        vec3_t                 ax;
        vec3_t                 ay;
        longint                radius;
        longint                sweep;
        longint                segs;
        longint                num;
        longint                q;
        longint                cs;
        longint                sn;
        longint                rc;
        longint                rs;
        longint unsigned       qm;
        arcpg_pkg::arcpg_out_t p;
        radius = a.radius_value;
        sweep  = a.sweep_angle;
        segs   = a.segment_count;
        ctr    = '{a.centre_x, a.centre_y, a.centre_z};
        nrm    = '{a.normal_x, a.normal_y, a.normal_z};
        if (radius <= 0)
            queue_point(error_point(arcpg_pkg::ERR_RADIUS));
        else if (sweep == 0)
            queue_point(error_point(arcpg_pkg::ERR_SWEEP));
        else if (segs < arcpg_pkg::MIN_SEGMENTS_DEF || segs > arcpg_pkg::MAX_SEGMENTS_DEF)
            queue_point(error_point(arcpg_pkg::ERR_SEGS));
        else if (nrm[0] == 0 && nrm[1] == 0 && nrm[2] == 0)
            queue_point(error_point(arcpg_pkg::ERR_NORMAL));
        else
        begin
            unit_vec(nrm, un);
            // seed axis z unless the normal is close to z
            if (((un[2] < 0) ? -un[2] : un[2]) < SEED_Q30)
                t = '{un[1], -un[0], 0};
            else
                t = '{0, un[2], -un[1]};
            unit_vec(t, ax);
            t[0] = round_shift(un[1] * ax[2] - un[2] * ax[1], 30);
            t[1] = round_shift(un[2] * ax[0] - un[0] * ax[2], 30);
            t[2] = round_shift(un[0] * ax[1] - un[1] * ax[0], 30);
            unit_vec(t, ay);
            for (longint i = 0; i <= segs; i++)
            begin
                num = sweep * i;
                qm  = (((num < 0) ? longint'(-num) : num) + segs / 2) / segs;
                q   = (num < 0) ? -longint'(qm) : longint'(qm);
                cordic_sin_cos(longint'(a.start_angle) + q, cs, sn);
                rc           = round_shift(radius * cs, 30);
                rs           = round_shift(radius * sn, 30);
                p.point_x    = clamp32(ctr[0] + round_shift(ax[0] * rc + ay[0] * rs, 30));
                p.point_y    = clamp32(ctr[1] + round_shift(ax[1] * rc + ay[1] * rs, 30));
                p.point_z    = clamp32(ctr[2] + round_shift(ax[2] * rc + ay[2] * rs, 30));
                p.error_code = arcpg_pkg::ERR_NONE;
                p.last_point = (i == segs);
                queue_point(p);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------

    function automatic arcpg_pkg::arcpg_in_t make_arc(input int cx, input int cy,
                                                      input int cz, input int nx,
                                                      input int ny, input int nz,
                                                      input int r, input int st,
                                                      input int sw, input int segs);
        arcpg_pkg::arcpg_in_t a;
        a.centre_x      = cx;
        a.centre_y      = cy;
        a.centre_z      = cz;
        a.normal_x      = nx;
        a.normal_y      = ny;
        a.normal_z      = nz;
        a.radius_value  = r;
        a.start_angle   = st;
        a.sweep_angle   = sw;
        a.segment_count = segs[7:0];
        return a;
    endfunction

    function automatic arcpg_pkg::arcpg_in_t random_arc();
        arcpg_pkg::arcpg_in_t a;
        int unsigned          pick;
        a    = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, 8'($urandom)};
        pick = $urandom_range(0, 99);
        if (pick < 12)
            return a;   // raw noise, mostly rejected
        if (pick < 20)
            a.centre_x = $urandom_range(0, 1) ? 32'sh7fff0000 : 32'sh80010000;
        else
        begin
            a.centre_x = $signed(32'($urandom_range(0, 32'h01ffffff))) - 32'sh01000000;
            a.centre_y = $signed(32'($urandom_range(0, 32'h01ffffff))) - 32'sh01000000;
            a.centre_z = $signed(32'($urandom_range(0, 32'h01ffffff))) - 32'sh01000000;
        end
        a.radius_value = $urandom_range(1, 32'h7fffffff);
        if ($urandom_range(0, 3) != 0)
            a.radius_value = $urandom_range(1, 32'h00ffffff);
        if ($urandom_range(0, 3) == 0)
        begin
            // short normals exercise the scaling step
            a.normal_x = $signed(32'($urandom_range(0, 15))) - 8;
            a.normal_y = $signed(32'($urandom_range(0, 15))) - 8;
            a.normal_z = $signed(32'($urandom_range(0, 15))) - 8;
        end
        if (a.normal_x == 0 && a.normal_y == 0 && a.normal_z == 0)
            a.normal_z = 1;
        if (a.sweep_angle == 0)
            a.sweep_angle = 1;
        if ($urandom_range(0, 9) == 0)
            a.segment_count = 8'($urandom_range(1, arcpg_pkg::MAX_SEGMENTS_DEF));
        else
            a.segment_count = 8'($urandom_range(1, 8));
        return a;
    endfunction

    // directed rows
    initial
    begin
        add_row(make_arc(0, 0, 0, 0, 0, 65536, 0, 0, 268435456, 4), arcpg_pkg::ERR_RADIUS);
        add_row(make_arc(0, 0, 0, 0, 0, 65536, 32'h80000000, 0, 0, 0),
                arcpg_pkg::ERR_RADIUS);
        add_row(make_arc(0, 0, 0, 0, 0, 65536, 65536, 0, 0, 0), arcpg_pkg::ERR_SWEEP);
        add_row(make_arc(0, 0, 0, 0, 0, 0, 65536, 0, 1, 0), arcpg_pkg::ERR_SEGS);
        add_row(make_arc(0, 0, 0, 0, 0, 65536, 65536, 0, 1, 64), arcpg_pkg::ERR_SEGS);
        add_row(make_arc(0, 0, 0, 0, 0, 65536, 65536, 0, 1, 255), arcpg_pkg::ERR_SEGS);
        add_row(make_arc(0, 0, 0, 0, 0, 0, 65536, 0, 1, 1), arcpg_pkg::ERR_NORMAL);
        // normal along z, then along x, y, and a short one
        add_row(make_arc(0, 0, 0, 0, 0, 65536, 65536, 0, 421657428, 4),
                arcpg_pkg::ERR_NONE);
        add_row(make_arc(65536, -65536, 0, 65536, 0, 0, 131072, 0, -843314857, 1),
                arcpg_pkg::ERR_NONE);
        add_row(make_arc(0, 0, 0, 0, -65536, 0, 65536, 100, 1, 63), arcpg_pkg::ERR_NONE);
        add_row(make_arc(0, 0, 0, 1, 1, 1, 1, 0, 32'h7fffffff, 3), arcpg_pkg::ERR_NONE);
        // extreme normals and radius
        add_row(make_arc(0, 0, 0, 32'h80000000, 32'h80000000, 32'h80000000,
                         32'h7fffffff, 0, 32'h80000000, 5), arcpg_pkg::ERR_NONE);
        add_row(make_arc(0, 0, 0, 32'h7fffffff, 0, 32'h80000000,
                         32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 2),
                arcpg_pkg::ERR_NONE);
        // saturation at both ends of the coordinate range
        add_row(make_arc(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 3, -5, 7,
                         32'h40000000, 0, 421657428, 6), arcpg_pkg::ERR_NONE);
        add_row(make_arc(32'h80000000, 32'h80000000, 32'h80000000, -2, 9, 1,
                         32'h40000000, 32'h80000000, -421657428, 6),
                arcpg_pkg::ERR_NONE);
        // start plus sweep beyond the angle range
        add_row(make_arc(0, 0, 0, 0, 65536, 65536, 65536, 32'h7fffffff,
                         32'h7fffffff, 63), arcpg_pkg::ERR_NONE);
        add_row(make_arc(0, 0, 0, 0, 65536, 65536, 65536, 32'h80000000,
                         32'h80000000, 7), arcpg_pkg::ERR_NONE);
    end

    // ---------------------------------------------------------------
    // arc request driver
    // ---------------------------------------------------------------
    initial
    begin
        arcpg_pkg::arcpg_in_t a;
        int                   n_total;
        rst_n     = 1'b0;
        arc_valid = 1'b0;
        arc       = '0;
        steady    = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        #0;
        n_total = arc_rows.size() + RANDOM_ARCS;
        for (int n = 0; n < n_total; n++)
        begin
            steady <= (n >= 80 && n < 130);
            // random gap before this request
            if (!(n >= 80 && n < 130) && $urandom_range(0, 99) < 36)
            begin
                arc_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            a = (n < arc_rows.size()) ? arc_rows[n].arc : random_arc();
            arc       <= a;
            arc_valid <= 1'b1;
            do
                @(posedge clk);
            while (!arc_ready);
            // accepted at this edge
            if (n < arc_rows.size() && arc_rows[n].err != arcpg_pkg::ERR_NONE)
                queue_point(error_point(arc_rows[n].err));
            else
                predict_arc_points(a);
        end
        arc_valid <= 1'b0;
        steady    <= 1'b0;
        while (points_due.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (mismatches == 0)
            $display("[arc_point_generator] OK");
        else
            $display("[arc_point_generator] ERROR");
        $finish;
    end

    // ---------------------------------------------------------------
    // point receiver and checker
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        arcpg_pkg::arcpg_out_t want;
        if (rst_n && point_valid && point_ready)
        begin
            if (points_due.size() == 0)
                report($sformatf("point with nothing expected: %h", point));
            else
            begin
                want = points_due.pop_front();
                if (point.point_x !== want.point_x || point.point_y !== want.point_y ||
                    point.point_z !== want.point_z || point.error_code !== want.error_code ||
                    point.last_point !== want.last_point)
                    report($sformatf("got %0d %0d %0d err %0d last %0b, want %0d %0d %0d err %0d last %0b",
                        point.point_x, point.point_y, point.point_z, point.error_code,
                        point.last_point, want.point_x, want.point_y, want.point_z,
                        want.error_code, want.last_point));
            end
        end
        point_ready <= steady || ($urandom_range(0, 99) >= 36);
    end

    // limit on the whole run
    initial
    begin
        #40ms;
        $display("[arc_point_generator] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/arcpg_pkg.sv
rtl/arcpg_divsqrt.sv
rtl/arcpg_cordic.sv
rtl/arc_point_generator.sv
test/tb_arc_point_generator.sv
